// ===== hw/rtl/mwg_pkg.sv =====
package mwg_pkg;

   localparam int IDX_W       = 16;
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int PERIOD_W    = 16;
   localparam int SEL_W       = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int SINE_ROM_DEPTH_DEFAULT = 1024;
   localparam int PHASE_BITS_DEFAULT     = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1024;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd32768;

   localparam int  ORGAN_LANES = 6;
   localparam real HALF_PI     = 1.5707963267948966;

   typedef enum logic [SEL_W-1:0] {
      WAVE_SINE      = 3'd0,
      WAVE_SQUARE    = 3'd1,
      WAVE_TRIANGLE  = 3'd2,
      WAVE_SAW       = 3'd3,
      WAVE_ORGAN     = 3'd4,
      WAVE_SIXTEENTH = 3'd5
   } wave_sel_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WAVEFORM_SELECT = 2'd0,
      CSR_PERIOD_LENGTH   = 2'd1,
      CSR_GAIN            = 2'd2
   } csr_index_type;

   // round(32767 * sin(pi/2 * m / depth)), halves away from zero
   function automatic logic signed [SAMPLE_W-1:0] quarter_sine(int unsigned m,
                                                              int unsigned depth,
                                                              real step);
      real x;
      int  v;
      if (m == 0) begin
         return '0;
      end
      if (3 * m == depth) begin
         return 16'sd16384;
      end
      x = 32767.0 * $sin(HALF_PI * real'(m) * step);
      v = $rtoi(x + 0.5);
      if (v > 32767) begin
         v = 32767;
      end
      return SAMPLE_W'(v);
   endfunction

endpackage

// ===== hw/rtl/mwg_phase_div.sv =====
module mwg_phase_div
   import mwg_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEFAULT,
   parameter int N_DIV      = IDX_W + PHASE_BITS
) (
   input  logic                  clock,
   input  logic [N_DIV-1:0]      stage_en,
   input  logic [IDX_W-1:0]      sample_index,
   input  logic [PERIOD_W:0]     len,
   output logic [PHASE_BITS-1:0] phase
);

   // first IDX_W stages: index mod len, one bit per stage
   // remaining PHASE_BITS stages: ((index mod len) << PHASE_BITS) / len, one quotient bit per stage
   logic [IDX_W-1:0]      rem_ff [N_DIV];
   logic [IDX_W-1:0]      num_ff [N_DIV];
   logic [PHASE_BITS-1:0] quo_ff [N_DIV];

   for (genvar j = 0; j < N_DIV; j++) begin : g_stage
      logic [IDX_W-1:0]      rem_prev;
      logic [IDX_W-1:0]      num_prev;
      logic [PHASE_BITS-1:0] quo_prev;
      logic [IDX_W:0]        trial;
      logic                  ge;
      logic [IDX_W-1:0]      rem_in;
      logic [IDX_W-1:0]      num_in;
      logic [PHASE_BITS-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = sample_index;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign num_prev = num_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      if (j < IDX_W) begin : g_mod
         assign trial  = {rem_prev, num_prev[IDX_W-1]};
         assign num_in = {num_prev[IDX_W-2:0], 1'b0};
         assign quo_in = quo_prev;
      end else begin : g_quo
         assign trial  = {rem_prev, 1'b0};
         assign num_in = num_prev;
         assign quo_in = {quo_prev[PHASE_BITS-2:0], ge};
      end

      always_comb begin
         ge     = (trial >= len);
         rem_in = ge ? IDX_W'(trial - len) : IDX_W'(trial);
      end

      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j] <= rem_in;
            num_ff[j] <= num_in;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign phase = quo_ff[N_DIV-1];

endmodule

// ===== hw/rtl/mwg_sine_rom.sv =====
module mwg_sine_rom
   import mwg_pkg::*;
#(
   parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEFAULT,
   parameter int ADDR_W         = $clog2(SINE_ROM_DEPTH)
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          addr,
   output logic signed [SAMPLE_W-1:0] rd_data
);

   localparam real STEP = 1.0 / real'(SINE_ROM_DEPTH);

   logic signed [SAMPLE_W-1:0] rom_tbl [SINE_ROM_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_ff;

   // full period folded from the quarter wave
   for (genvar k = 0; k < SINE_ROM_DEPTH; k++) begin : g_entry
      localparam int unsigned N4   = 4 * k;
      localparam int unsigned QUAD = N4 / SINE_ROM_DEPTH;
      localparam int unsigned REM  = N4 % SINE_ROM_DEPTH;
      localparam int unsigned M    = (QUAD % 2 == 1) ? (SINE_ROM_DEPTH - REM) : REM;
      localparam logic signed [SAMPLE_W-1:0] Q = quarter_sine(M, SINE_ROM_DEPTH, STEP);
      assign rom_tbl[k] = (QUAD >= 2) ? -Q : Q;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= rom_tbl[addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

// ===== hw/rtl/mwg_wave.sv =====
module mwg_wave
   import mwg_pkg::*;
#(
   parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEFAULT,
   parameter int PHASE_BITS     = PHASE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic [2:0]                 stage_en,
   input  logic [PHASE_BITS-1:0]      phase,
   input  logic [SEL_W-1:0]           wave_sel,
   output logic signed [SAMPLE_W-1:0] wave
);

   localparam int ADDR_W  = $clog2(SINE_ROM_DEPTH);
   localparam int AMUL_W  = PHASE_BITS + ADDR_W + 1;
   localparam int HMUL_W  = PHASE_BITS + 3;
   localparam int TRI_W   = 17;
   localparam int SUM_W   = SAMPLE_W + 4;

   // stage a: harmonic phases to rom addresses, linear shapes
   logic [ADDR_W-1:0]          addr_ff [ORGAN_LANES];
   logic signed [SAMPLE_W-1:0] lin_ff;
   // stage b: rom reads
   logic signed [SAMPLE_W-1:0] sine_rd [ORGAN_LANES];
   logic signed [SAMPLE_W-1:0] lin_b_ff;
   // stage c: selected waveform
   logic signed [SAMPLE_W-1:0] wave_ff;
   logic signed [SAMPLE_W-1:0] wave_in;

   logic                       sixteenth;
   assign sixteenth = (wave_sel == WAVE_SIXTEENTH);

   for (genvar k = 0; k < ORGAN_LANES; k++) begin : g_lane
      logic [HMUL_W-1:0]     hmul;
      logic [PHASE_BITS-1:0] hphase;
      logic [AMUL_W-1:0]     amul;

      always_comb begin
         hmul = HMUL_W'(phase) * HMUL_W'(k + 1);
         // lane 0 also serves the sixteenth harmonic
         if (k == 0 && sixteenth) begin
            hphase = {phase[PHASE_BITS-5:0], 4'b0};
         end else begin
            hphase = hmul[PHASE_BITS-1:0];
         end
         amul = AMUL_W'(hphase) * AMUL_W'(SINE_ROM_DEPTH);
      end

      always_ff @(posedge clock) begin
         if (stage_en[0]) begin
            addr_ff[k] <= ADDR_W'(amul >> PHASE_BITS);
         end
      end

      mwg_sine_rom #(
         .SINE_ROM_DEPTH(SINE_ROM_DEPTH),
         .ADDR_W        (ADDR_W)
      ) u_rom (
         .clock  (clock),
         .rd_en  (stage_en[1]),
         .addr   (addr_ff[k]),
         .rd_data(sine_rd[k])
      );
   end

   logic [PHASE_BITS+TRI_W-1:0]   tri_wide;
   logic [TRI_W-1:0]              tri_u;
   logic signed [TRI_W+1:0]       tri_s;
   logic signed [TRI_W+1:0]       tri_w;
   logic signed [SAMPLE_W-1:0]    tri_val;
   logic [PHASE_BITS+SAMPLE_W-1:0] saw_wide;
   logic [SAMPLE_W-1:0]           saw_u;
   logic signed [SAMPLE_W-1:0]    lin_in;

   always_comb begin
      tri_wide = {phase, {TRI_W{1'b0}}} >> PHASE_BITS;
      tri_u    = tri_wide[TRI_W-1:0];
      tri_s    = $signed({2'b00, tri_u});
      if (tri_u <= TRI_W'(32768)) begin
         tri_w = tri_s;
      end else if (tri_u <= TRI_W'(98304)) begin
         tri_w = 19'sd65536 - tri_s;
      end else begin
         tri_w = tri_s - 19'sd131072;
      end
      // the +1.0 peak is held at full scale
      if (tri_w > 19'sd32767) begin
         tri_val = 16'sd32767;
      end else begin
         tri_val = SAMPLE_W'(tri_w);
      end
      saw_wide = {phase, {SAMPLE_W{1'b0}}} >> PHASE_BITS;
      saw_u    = saw_wide[SAMPLE_W-1:0];
      lin_in   = (wave_sel == WAVE_SAW) ? $signed({~saw_u[SAMPLE_W-1], saw_u[SAMPLE_W-2:0]})
                                        : tri_val;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         lin_ff <= lin_in;
      end
      if (stage_en[1]) begin
         lin_b_ff <= lin_ff;
      end
   end

   logic signed [SUM_W-1:0] organ_sum;
   logic signed [SUM_W-1:0] organ_div;

   always_comb begin
      organ_sum = SUM_W'(sine_rd[0]) + SUM_W'(sine_rd[1]) + SUM_W'(3) * SUM_W'(sine_rd[2])
                + SUM_W'(sine_rd[3]) + SUM_W'(sine_rd[4]) + SUM_W'(sine_rd[5]);
      organ_div = organ_sum >>> 3;
      case (wave_sel)
         WAVE_SINE:      wave_in = sine_rd[0];
         WAVE_SQUARE:    wave_in = (sine_rd[0] > 16'sd0) ? 16'sd32767 : -16'sd32768;
         WAVE_TRIANGLE:  wave_in = lin_b_ff;
         WAVE_SAW:       wave_in = lin_b_ff;
         WAVE_ORGAN:     wave_in = SAMPLE_W'(organ_div);
         WAVE_SIXTEENTH: wave_in = sine_rd[0];
         default:        wave_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         wave_ff <= wave_in;
      end
   end

   assign wave = wave_ff;

endmodule

// ===== hw/rtl/mwg_gain.sv =====
module mwg_gain
   import mwg_pkg::*;
(
   input  logic                       clock,
   input  logic [1:0]                 stage_en,
   input  logic signed [SAMPLE_W-1:0] wave,
   input  logic [GAIN_W-1:0]          gain,
   output logic signed [SAMPLE_W-1:0] sample,
   output logic                       clipped
);

   localparam int PROD_W   = SAMPLE_W + GAIN_W + 2;
   localparam int SCALED_W = PROD_W - 15;

   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [SCALED_W-1:0] scaled;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic                       clipped_ff;
   logic                       clipped_in;

   always_comb begin
      prod_in = PROD_W'(wave * $signed({1'b0, gain})) + PROD_W'(16384);
   end

   always_comb begin
      // floor division by 32768, then saturate
      scaled = SCALED_W'(prod_ff >>> 15);
      if (scaled > SCALED_W'(32767)) begin
         sample_in  = 16'sd32767;
         clipped_in = 1'b1;
      end else if (scaled < -SCALED_W'(32768)) begin
         sample_in  = -16'sd32768;
         clipped_in = 1'b1;
      end else begin
         sample_in  = SAMPLE_W'(scaled);
         clipped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[1]) begin
         sample_ff  <= sample_in;
         clipped_ff <= clipped_in;
      end
   end

   assign sample  = sample_ff;
   assign clipped = clipped_ff;

endmodule

// ===== hw/rtl/multi_waveform_generator_unit.sv =====
// Multi-waveform generator: each request carries a table index; the unit returns one signed
// Q1.15 sample of one period of the selected waveform (sine, square, triangle, saw, organ
// sum of six harmonics, or sixteenth harmonic), scaled by gain and saturated, with a clipped
// flag. One request is taken every cycle while the pipeline does not stall. Most of the pipeline
// is the restoring divider, one quotient bit per stage, first for index mod period_length and
// then for the phase (remainder * 2^PHASE_BITS / period_length); the rest is address, registered
// sine rom read (six rom copies), waveform select, gain multiply and saturation. A stalled
// response holds the output stage while earlier stages keep filling bubbles. Write the
// configuration registers only while no request is in flight.
module multi_waveform_generator_unit
   import mwg_pkg::*;
#(
   parameter int SINE_ROM_DEPTH = SINE_ROM_DEPTH_DEFAULT,
   parameter int PHASE_BITS     = PHASE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [IDX_W-1:0]           req_sample_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_clipped,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   localparam int N_DIV    = IDX_W + PHASE_BITS;
   localparam int N_STAGES = N_DIV + 5;

   logic [SEL_W-1:0]    wave_sel_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [GAIN_W-1:0]   gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_sel_ff <= WAVE_SINE;
         period_ff   <= PERIOD_RESET;
         gain_ff     <= GAIN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WAVEFORM_SELECT: wave_sel_ff <= csr_write_data[SEL_W-1:0];
            CSR_PERIOD_LENGTH:   period_ff   <= csr_write_data[PERIOD_W-1:0];
            CSR_GAIN:            gain_ff     <= csr_write_data[GAIN_W-1:0];
            default:             ;
         endcase
      end
   end

   // zero period means 65536
   logic [PERIOD_W:0] len;
   assign len = (period_ff == '0) ? {1'b1, {PERIOD_W{1'b0}}} : {1'b0, period_ff};

   // valid bits per stage; a stage loads when empty or when the next one moves
   logic [N_STAGES-1:0] vld_ff;
   logic [N_STAGES-1:0] vld_in;
   logic [N_STAGES-1:0] stage_en;

   assign stage_en[N_STAGES-1] = !vld_ff[N_STAGES-1] || !rsp_stall;
   for (genvar i = 0; i < N_STAGES - 1; i++) begin : g_ready
      assign stage_en[i] = !vld_ff[i] || stage_en[i+1];
   end

   assign vld_in = {vld_ff[N_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < N_STAGES; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = vld_ff[N_STAGES-1];

   logic [PHASE_BITS-1:0]      phase;
   logic signed [SAMPLE_W-1:0] wave;

   mwg_phase_div #(
      .PHASE_BITS(PHASE_BITS),
      .N_DIV     (N_DIV)
   ) u_div (
      .clock       (clock),
      .stage_en    (stage_en[N_DIV-1:0]),
      .sample_index(req_sample_index),
      .len         (len),
      .phase       (phase)
   );

   mwg_wave #(
      .SINE_ROM_DEPTH(SINE_ROM_DEPTH),
      .PHASE_BITS    (PHASE_BITS)
   ) u_wave (
      .clock   (clock),
      .stage_en(stage_en[N_DIV+2:N_DIV]),
      .phase   (phase),
      .wave_sel(wave_sel_ff),
      .wave    (wave)
   );

   mwg_gain u_gain (
      .clock   (clock),
      .stage_en(stage_en[N_DIV+4:N_DIV+3]),
      .wave    (wave),
      .gain    (gain_ff),
      .sample  (rsp_sample),
      .clipped (rsp_clipped)
   );

endmodule

// ===== hw/rtl/mwg_checker.sv =====
module mwg_checker
   import mwg_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_sample,
   input logic                       rsp_clipped
);

   // a waiting response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_clipped))
      else $error("response changed while stalled");

   // clipping only ever lands on a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_sample == 16'sh7fff || rsp_sample == 16'sh8000)
      else $error("clipped sample not at full scale");

   // a free output stage means the whole pipe can advance
   a_no_false_stall: assert property (@(posedge clock)
      !rsp_valid || !rsp_stall |-> !req_stall)
      else $error("request stalled with output free");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

   // a request waiting at the input keeps asking
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request dropped while stalled");

endmodule

bind multi_waveform_generator_unit mwg_checker u_checker (.*);

// ===== dv/multi_waveform_generator_unit_tb.sv =====
`timescale 1ns / 1ps

module multi_waveform_generator_unit_tb;
   import mwg_pkg::*;

   localparam int ROM_DEPTH      = SINE_ROM_DEPTH_DEFAULT;
   localparam int PHASE_W        = PHASE_BITS_DEFAULT;
   localparam longint PHASE_MASK = (longint'(1) << PHASE_W) - 1;
   localparam real QUARTER_TURN  = 3.14159265358979323846 / 2.0;
   localparam int CYCLE_LIMIT    = 600000;
   localparam int DRAIN_CYCLES   = 45;

   // select codes the block treats as silence
   localparam logic [SEL_W-1:0] WAVE_SILENT_A = 3'd6;
   localparam logic [SEL_W-1:0] WAVE_SILENT_B = 3'd7;

   typedef struct {
      logic [IDX_W-1:0]           index;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clipped;
   } wave_result_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [IDX_W-1:0]           req_sample_index = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_clipped;
   logic                       csr_write_enable = 1'b0;
   csr_index_type              csr_index = CSR_WAVEFORM_SELECT;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;

   logic signed [SAMPLE_W-1:0] sine_table [ROM_DEPTH];
   logic [SEL_W-1:0]           cur_select = WAVE_SINE;
   logic [PERIOD_W-1:0]        cur_period = PERIOD_RESET;
   logic [GAIN_W-1:0]          cur_gain   = GAIN_RESET;

   wave_result_type expected_samples [$];
   int           error_count       = 0;
   int           cycle_count       = 0;
   int           stall_cycles_left = 0;
   bit           req_gaps_on       = 1'b1;
   bit           rsp_stalls_on     = 1'b1;

   multi_waveform_generator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_clipped      (rsp_clipped),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // full-period table built from a mirrored quarter wave
   function automatic void build_sine_table();
      int unsigned quad, rem, m;
      int          s;
      real         x;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         quad = (4 * k) / ROM_DEPTH;
         rem  = (4 * k) % ROM_DEPTH;
         m    = quad[0] ? ROM_DEPTH - rem : rem;
         if (m == 0) begin
            s = 0;
         end else if (3 * m == ROM_DEPTH) begin
            s = 16384;
         end else begin
            x = 32767.0 * $sin(QUARTER_TURN * real'(m) / real'(ROM_DEPTH));
            s = $rtoi(x + 0.5);
            if (s > 32767) begin
               s = 32767;
            end
         end
         sine_table[k] = SAMPLE_W'((quad >= 2) ? -s : s);
      end
   endfunction

   function automatic int harmonic_sine(input longint unsigned phase, input int unsigned h);
      longint unsigned ph, addr;
      ph   = (phase * h) & PHASE_MASK;
      addr = ((ph * ROM_DEPTH) >> PHASE_W) % ROM_DEPTH;
      return int'(sine_table[addr]);
   endfunction

   function automatic wave_result_type compute_sample(input logic [IDX_W-1:0] index);
      wave_result_type res;
      longint unsigned len, pos, phase;
      int              w, tri_u, g;
      longint          scaled;
      res.index   = index;
      res.sample  = '0;
      res.clipped = 1'b0;
      len   = (cur_period == 0) ? 65536 : cur_period;
      pos   = index % len;
      phase = ((pos << PHASE_W) / len) & PHASE_MASK;
      g     = int'(cur_gain);
      case (cur_select)
         WAVE_SINE:      w = harmonic_sine(phase, 1);
         WAVE_SQUARE:    w = (harmonic_sine(phase, 1) > 0) ? 32767 : -32768;
         WAVE_TRIANGLE: begin
            tri_u = int'((phase * 131072) >> PHASE_W);
            if (tri_u <= 32768) begin
               w = tri_u;
            end else if (tri_u <= 98304) begin
               w = 65536 - tri_u;
            end else begin
               w = tri_u - 131072;
            end
            // the +1.0 peak is limited here, not flagged as clipping
            if (w > 32767) begin
               w = 32767;
            end
         end
         WAVE_SAW:       w = int'((phase * 65536) >> PHASE_W) - 32768;
         WAVE_ORGAN: begin
            w = harmonic_sine(phase, 1) + harmonic_sine(phase, 2) + 3 * harmonic_sine(phase, 3)
              + harmonic_sine(phase, 4) + harmonic_sine(phase, 5) + harmonic_sine(phase, 6);
            w = w >>> 3;
         end
         WAVE_SIXTEENTH: w = harmonic_sine(phase, 16);
         default:        return res;
      endcase
      scaled = (longint'(w) * longint'(g) + 16384) >>> 15;
      if (scaled > 32767) begin
         scaled      = 32767;
         res.clipped = 1'b1;
      end else if (scaled < -32768) begin
         scaled      = -32768;
         res.clipped = 1'b1;
      end
      res.sample = SAMPLE_W'(scaled);
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) begin
         $display("ERROR %0t: %s", $time, msg);
      end
   endtask

   task automatic check_result(input logic signed [SAMPLE_W-1:0] got_sample, input logic got_clip);
      wave_result_type want;
      if (expected_samples.size() == 0) begin
         report_mismatch($sformatf("response with none pending: sample %0d clipped %0b",
                                   got_sample, got_clip));
      end else begin
         want = expected_samples.pop_front();
         if (got_sample !== want.sample) begin
            report_mismatch($sformatf("index %0d: sample %0d, wanted %0d",
                                      want.index, got_sample, want.sample));
         end
         if (got_clip !== want.clipped) begin
            report_mismatch($sformatf("index %0d: clipped %0b, wanted %0b",
                                      want.index, got_clip, want.clipped));
         end
      end
   endtask

   // response side: check accepted results, then decide next stall
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_sample, rsp_clipped);
         end
         if (stall_cycles_left > 0) begin
            stall_cycles_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 25) begin
            stall_cycles_left = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3)
                                                             : $urandom_range(8, 40);
         end
         rsp_stall <= (stall_cycles_left > 0);
      end
   end

   task automatic send_request(input logic [IDX_W-1:0] index);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_index <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_samples.push_back(compute_sample(index));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
   endtask

   task automatic set_register(input csr_index_type which, input logic [CSR_DATA_W-1:0] value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (which)
         CSR_WAVEFORM_SELECT: cur_select = value[SEL_W-1:0];
         CSR_PERIOD_LENGTH:   cur_period = value;
         CSR_GAIN:            cur_gain   = value;
         default: ;
      endcase
   endtask

   task automatic set_all(input logic [SEL_W-1:0] sel, input logic [PERIOD_W-1:0] period,
                          input logic [GAIN_W-1:0] g);
      set_register(CSR_WAVEFORM_SELECT, CSR_DATA_W'(sel));
      set_register(CSR_PERIOD_LENGTH, period);
      set_register(CSR_GAIN, g);
   endtask

   function automatic logic [IDX_W-1:0] pick_index(input logic [PERIOD_W-1:0] period);
      int unsigned len;
      int          r;
      len = (period == 0) ? 65536 : period;
      r   = $urandom_range(0, 99);
      if (r < 50) begin
         return IDX_W'($urandom_range(0, 65535));
      end else if (r < 85) begin
         return IDX_W'($urandom_range(0, len - 1));
      end else if (r < 92) begin
         return IDX_W'(len - 1);
      end
      return IDX_W'(len * $urandom_range(0, 3));
   endfunction

   // reset values: unity sine over 1024 samples
   task automatic test_reset_defaults();
      send_request(16'd0);
      send_request(16'd256);
      send_request(16'd768);
      send_request(16'd1023);
      send_request(16'hFFFF);
   endtask

   task automatic test_waveform_shapes();
      set_all(WAVE_SQUARE, 16'd4, GAIN_RESET);
      for (int i = 0; i < 4; i++) send_request(IDX_W'(i));
      // quarter-period index lands on the triangle peak
      set_register(CSR_WAVEFORM_SELECT, CSR_DATA_W'(WAVE_TRIANGLE));
      for (int i = 0; i < 4; i++) send_request(IDX_W'(i));
      // zero period means a full 65536-sample table
      set_all(WAVE_ORGAN, 16'd0, GAIN_RESET);
      send_request(16'd0);
      send_request(16'd5461);
      send_request(16'hFFFF);
      set_all(WAVE_SIXTEENTH, 16'hFFFF, GAIN_RESET);
      send_request(16'd12345);
      send_request(16'hFFFE);
   endtask

   task automatic test_gain_extremes();
      set_all(WAVE_SAW, 16'hFFFF, 16'hFFFF);
      send_request(16'd0);
      send_request(16'hFFFE);
      set_all(WAVE_SINE, 16'd1024, 16'd0);
      send_request(16'd256);
      set_all(WAVE_SINE, 16'd1, GAIN_RESET);
      send_request(16'hFFFF);
   endtask

   task automatic test_unused_selects();
      set_all(WAVE_SILENT_A, 16'd100, 16'hFFFF);
      send_request(16'd25);
      set_register(CSR_WAVEFORM_SELECT, CSR_DATA_W'(WAVE_SILENT_B));
      send_request(16'hFFFF);
   endtask

   task automatic test_random_phases();
      logic [SEL_W-1:0]    sel;
      logic [PERIOD_W-1:0] period;
      logic [GAIN_W-1:0]   g;
      int                  r;
      for (int ph = 0; ph < 12; ph++) begin
         sel = (ph < 8) ? SEL_W'(ph) : SEL_W'($urandom_range(0, 5));
         r   = $urandom_range(0, 9);
         if (r == 0) begin
            period = 16'd0;
         end else if (r == 1) begin
            period = 16'd1;
         end else if (r == 2) begin
            period = 16'hFFFF;
         end else if (r < 6) begin
            period = PERIOD_W'($urandom_range(2, 64));
         end else if (r < 8) begin
            period = PERIOD_W'($urandom_range(65, 4096));
         end else begin
            period = PERIOD_W'($urandom_range(0, 65535));
         end
         r = $urandom_range(0, 7);
         if (r == 0) begin
            g = 16'd0;
         end else if (r == 1) begin
            g = 16'hFFFF;
         end else if (r < 5) begin
            g = GAIN_RESET;
         end else begin
            g = GAIN_W'($urandom_range(0, 65535));
         end
         set_all(sel, period, g);
         req_gaps_on   = (ph % 4 != 3);
         rsp_stalls_on = (ph % 3 != 2);
         for (int i = 0; i < 75; i++) begin
            send_request(pick_index(period));
            // occasionally let the pipeline run dry mid-stream
            if ($urandom_range(0, 39) == 0) begin
               wait_for_results();
            end
         end
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_back_to_back_stream();
      set_all(WAVE_ORGAN, PERIOD_W'($urandom_range(1, 65535)),
              GAIN_W'($urandom_range(32768, 65535)));
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      for (int i = 0; i < 60; i++) send_request(IDX_W'($urandom_range(0, 65535)));
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      build_sine_table();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_waveform_shapes();
      test_gain_extremes();
      test_unused_selects();
      test_random_phases();
      test_back_to_back_stream();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_samples.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
